/* hdl/ordered_key_value_table_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the ordered key-value table
// Shared clocking and reset for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_TABLE_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OKVT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OKVT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/okvt_pkg.sv */
// ---------------------------------------------------------------------------
// okvt_pkg
// Sizes, operation codes and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package okvt_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int FUNC_W     = 3;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd4;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // latch item, clear index and results
		logic rd_en;     // read entry at index
		logic idx_inc;   // step index
		logic hit;       // capture match results
		logic val_wr;    // replace value at index
		logic append;    // write new pair at end
		logic set_full;  // flag refused insert
		logic shift_wr;  // move entry read at index down one place
		logic cnt_dec;
		logic cnt_clr;
		logic out_load;  // move results into output register
	} okvt_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] req_func;  // func of the item on the port
		logic [FUNC_W-1:0] func;      // func of the latched item
		logic              match;
		logic              last;      // index is the last stored entry
		logic              empty;
		logic              full;
		logic              out_free;
	} okvt_sts_t;

endpackage

/* hdl/okvt_chan_if.sv */
// ---------------------------------------------------------------------------
// okvt channel interfaces
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface okvt_req_if;
	logic                              valid;
	logic                              ready;
	logic [okvt_pkg::FUNC_W-1:0]       func;
	logic [okvt_pkg::KEY_BITS-1:0]     key_word;
	logic [okvt_pkg::VALUE_BITS-1:0]   value_word;

	modport source (output valid, func, key_word, value_word, input ready);
	modport sink   (input valid, func, key_word, value_word, output ready);
endinterface

interface okvt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [okvt_pkg::VALUE_BITS-1:0]   result_value;
	logic [okvt_pkg::KEY_BITS-1:0]     result_key;
	logic [okvt_pkg::CNT_W-1:0]        entry_count;
	logic                              status;

	modport source (output valid, found, result_value, result_key, entry_count, status,
		input ready);
	modport sink   (input valid, found, result_value, result_key, entry_count, status,
		output ready);
endinterface

/* hdl/okvt_ctrl.sv */
// ---------------------------------------------------------------------------
// okvt_ctrl
// Sequencer: linear search, miss handling, order-keeping shift, response.
// ---------------------------------------------------------------------------
module okvt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  okvt_pkg::okvt_sts_t sts,
	output okvt_pkg::okvt_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_MISS  = 3'd3;
	localparam logic [2:0] ST_SH_RD = 3'd4;
	localparam logic [2:0] ST_SH_WR = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	logic [2:0] state_q, state_d;

	assign req_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					case (sts.req_func) inside
						okvt_pkg::FUNC_CLEAR: begin
							cmd.cnt_clr = 1'b1;
							state_d     = ST_RESP;
						end
						okvt_pkg::FUNC_SET, okvt_pkg::FUNC_GET,
						okvt_pkg::FUNC_REMOVE, okvt_pkg::FUNC_FIND: begin
							state_d = sts.empty ? ST_MISS : ST_RD;
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				if (sts.match) begin
					cmd.hit = 1'b1;
					state_d = ST_RESP;
					if (sts.func == okvt_pkg::FUNC_SET) begin
						cmd.val_wr = 1'b1;
					end else if (sts.func == okvt_pkg::FUNC_REMOVE) begin
						if (sts.last) begin
							cmd.cnt_dec = 1'b1;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = ST_SH_RD;
						end
					end
				end else if (sts.last) begin
					state_d = ST_MISS;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_RD;
				end
			end
			ST_MISS: begin
				if (sts.func == okvt_pkg::FUNC_SET) begin
					if (sts.full) cmd.set_full = 1'b1;
					else          cmd.append   = 1'b1;
				end
				state_d = ST_RESP;
			end
			ST_SH_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_SH_WR;
			end
			ST_SH_WR: begin
				cmd.shift_wr = 1'b1;
				if (sts.last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SH_RD;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

/* hdl/okvt_dpath.sv */
// ---------------------------------------------------------------------------
// okvt_dpath
// Key and value stores, index and count, result and output registers.
// ---------------------------------------------------------------------------
`include "ordered_key_value_table_assert.svh"

module okvt_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [okvt_pkg::FUNC_W-1:0]       req_func,
	input  logic [okvt_pkg::KEY_BITS-1:0]     req_key,
	input  logic [okvt_pkg::VALUE_BITS-1:0]   req_value,
	input  okvt_pkg::okvt_cmd_t               cmd,
	output okvt_pkg::okvt_sts_t               sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_found,
	output logic [okvt_pkg::VALUE_BITS-1:0]   out_value,
	output logic [okvt_pkg::KEY_BITS-1:0]     out_key,
	output logic [okvt_pkg::CNT_W-1:0]        out_count,
	output logic                              out_status
);

	// stores
	logic [okvt_pkg::KEY_BITS-1:0]   key_mem [okvt_pkg::ENTRIES];
	logic [okvt_pkg::VALUE_BITS-1:0] val_mem [okvt_pkg::ENTRIES];

	// latched item
	logic [okvt_pkg::FUNC_W-1:0]     func_q;
	logic [okvt_pkg::KEY_BITS-1:0]   key_q;
	logic [okvt_pkg::VALUE_BITS-1:0] val_q;

	// control state
	logic [okvt_pkg::IDX_W-1:0] idx_q;
	logic [okvt_pkg::CNT_W-1:0] cnt_q;
	logic                       out_valid_q;

	// read data and results
	logic [okvt_pkg::KEY_BITS-1:0]   rd_key_q;
	logic [okvt_pkg::VALUE_BITS-1:0] rd_val_q;
	logic                            res_found_q;
	logic [okvt_pkg::VALUE_BITS-1:0] res_value_q;
	logic [okvt_pkg::KEY_BITS-1:0]   res_key_q;
	logic                            res_status_q;

	// output register
	logic                            out_found_q;
	logic [okvt_pkg::VALUE_BITS-1:0] out_value_q;
	logic [okvt_pkg::KEY_BITS-1:0]   out_key_q;
	logic [okvt_pkg::CNT_W-1:0]      out_count_q;
	logic                            out_status_q;

	logic [okvt_pkg::CNT_W-1:0]      idx_nxt;
	logic                            key_we, val_we;
	logic [okvt_pkg::IDX_W-1:0]      wr_addr;
	logic [okvt_pkg::KEY_BITS-1:0]   wr_key;
	logic [okvt_pkg::VALUE_BITS-1:0] wr_val;

	assign idx_nxt = {1'b0, idx_q} + okvt_pkg::CNT_W'(1);

	// status toward the controller
	always_comb begin
		sts.req_func = req_func;
		sts.func     = func_q;
		sts.match    = (func_q == okvt_pkg::FUNC_FIND) ? (rd_val_q == val_q)
		                                               : (rd_key_q == key_q);
		sts.last     = (idx_nxt >= cnt_q);
		sts.empty    = (cnt_q == '0);
		sts.full     = (cnt_q == okvt_pkg::CNT_W'(okvt_pkg::ENTRIES));
		sts.out_free = !out_valid_q || out_ready;
	end

	// write port select: replace, append or shift down
	always_comb begin
		key_we  = cmd.append || cmd.shift_wr;
		val_we  = cmd.append || cmd.shift_wr || cmd.val_wr;
		wr_addr = idx_q;
		wr_key  = key_q;
		wr_val  = val_q;
		if (cmd.append) begin
			wr_addr = cnt_q[okvt_pkg::IDX_W-1:0];
		end else if (cmd.shift_wr) begin
			wr_addr = idx_q - okvt_pkg::IDX_W'(1);
			wr_key  = rd_key_q;
			wr_val  = rd_val_q;
		end
	end

	// stores with registered read
	always_ff @(posedge clk) begin
		if (key_we)     key_mem[wr_addr] <= wr_key;
		if (val_we)     val_mem[wr_addr] <= wr_val;
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[idx_q];
			rd_val_q <= val_mem[idx_q];
		end
	end

	// index, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)         idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + okvt_pkg::IDX_W'(1);

			if (cmd.cnt_clr)      cnt_q <= '0;
			else if (cmd.append)  cnt_q <= cnt_q + okvt_pkg::CNT_W'(1);
			else if (cmd.cnt_dec) cnt_q <= cnt_q - okvt_pkg::CNT_W'(1);

			if (cmd.out_load)     out_valid_q <= 1'b1;
			else if (out_ready)   out_valid_q <= 1'b0;
		end
	end

	// item latch, results and output payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q       <= req_func;
			key_q        <= req_key;
			val_q        <= req_value;
			res_found_q  <= 1'b0;
			res_value_q  <= '0;
			res_key_q    <= '0;
			res_status_q <= 1'b0;
		end else begin
			if (cmd.hit) begin
				res_found_q <= 1'b1;
				if (func_q == okvt_pkg::FUNC_GET || func_q == okvt_pkg::FUNC_REMOVE)
					res_value_q <= rd_val_q;
				if (func_q == okvt_pkg::FUNC_FIND)
					res_key_q <= rd_key_q;
			end
			if (cmd.set_full) res_status_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_found_q  <= res_found_q;
			out_value_q  <= res_value_q;
			out_key_q    <= res_key_q;
			out_count_q  <= cnt_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_found  = out_found_q;
	assign out_value  = out_value_q;
	assign out_key    = out_key_q;
	assign out_count  = out_count_q;
	assign out_status = out_status_q;

	// checks
	`OKVT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= okvt_pkg::CNT_W'(okvt_pkg::ENTRIES), "count above capacity")
	`OKVT_ASSERT_IMP(a_append_room, cmd.append, !sts.full, "append into full table")
	`OKVT_ASSERT_IMP(a_shift_idx, cmd.shift_wr, idx_q != '0, "shift write at index zero")
	`OKVT_ASSERT_IMP(a_out_slot, cmd.out_load, sts.out_free, "result overwrites pending output")
	`OKVT_ASSERT_NXT(a_dec_nonempty, cmd.cnt_dec, $past(cnt_q) != '0, "count decremented from zero")

endmodule

/* hdl/ordered_key_value_table.sv */
// Sequence, accept to result valid: clear and unused codes go straight to the response;
// a search examines entries in turn, each with one store read then one compare, and goes
// through the miss state on a miss; remove then moves each later entry down (read, write).
// Throughput: one item at a time; the next item is taken the cycle after the result is
// loaded into the output register. Reset: arst_n clears the count, controller and output
// valid; the key and value stores are not cleared (entries past the count are never read).
// ---------------------------------------------------------------------------
// ordered_key_value_table
// Insertion-ordered key-value table with linear search and shift-on-remove.
// ---------------------------------------------------------------------------
module ordered_key_value_table (
	input logic        clk,
	input logic        arst_n,
	okvt_req_if.sink   req,
	okvt_rsp_if.source rsp
);

	okvt_pkg::okvt_cmd_t cmd;
	okvt_pkg::okvt_sts_t sts;

	// sequencer
	okvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// stores and registers
	okvt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_func   (req.func),
		.req_key    (req.key_word),
		.req_value  (req.value_word),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_found  (rsp.found),
		.out_value  (rsp.result_value),
		.out_key    (rsp.result_key),
		.out_count  (rsp.entry_count),
		.out_status (rsp.status)
	);

endmodule
